[sv/ata_pkg.sv]
// Shared widths, constants and helper functions for the accelerometer tilt-angle block.
`default_nettype none

package ata_pkg;

  // Sample and guard widths
  localparam int SAMPLE_W = 16;
  localparam int GUARD_SH = 8;

  // Radicand for the magnitude root: (y*y + z*z) scaled by the guard bits squared
  localparam int SUM_W = 2 * SAMPLE_W;
  localparam int RAD_W = SUM_W + 2 * GUARD_SH;
  localparam int ROOT_W = RAD_W / 2;
  localparam int TRIAL_W = RAD_W + 2;

  // CORDIC vector and angle widths (angle in 2^-20 degree)
  localparam int CW = SAMPLE_W + GUARD_SH + 3;
  localparam int ZW = 29;
  localparam int STAGES = 16;
  localparam int TAB_LEN = 24;
  localparam int TAB_IDX_W = 5;

  // Angle scaling
  localparam int INT_ANG_FRAC = 20;
  localparam int ANGLE_FRAC = 7;
  localparam int RND_SH = INT_ANG_FRAC - ANGLE_FRAC;

  localparam logic signed [ZW-1:0] HALF_TURN_Z = ZW'(180 * (1 << INT_ANG_FRAC));
  localparam logic signed [ZW-1:0] QUARTER_TURN_Z = ZW'(90 * (1 << INT_ANG_FRAC));

  // Output fields
  localparam int ROLL_W = 16;
  localparam int PITCH_W = 15;
  localparam int ROLL_LIM = 180 * (1 << ANGLE_FRAC);
  localparam int PITCH_LIM = 90 * (1 << ANGLE_FRAC);

  // atan(2^-i) in units of 2^-20 degree
  function automatic logic signed [ZW-1:0] atan_tab(input logic [TAB_IDX_W-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 29'sd47185920;
      5'd1:    v = 29'sd27855475;
      5'd2:    v = 29'sd14718068;
      5'd3:    v = 29'sd7471121;
      5'd4:    v = 29'sd3750058;
      5'd5:    v = 29'sd1876857;
      5'd6:    v = 29'sd938658;
      5'd7:    v = 29'sd469357;
      5'd8:    v = 29'sd234682;
      5'd9:    v = 29'sd117342;
      5'd10:   v = 29'sd58671;
      5'd11:   v = 29'sd29335;
      5'd12:   v = 29'sd14668;
      5'd13:   v = 29'sd7334;
      5'd14:   v = 29'sd3667;
      5'd15:   v = 29'sd1833;
      5'd16:   v = 29'sd917;
      5'd17:   v = 29'sd458;
      5'd18:   v = 29'sd229;
      5'd19:   v = 29'sd115;
      5'd20:   v = 29'sd57;
      5'd21:   v = 29'sd29;
      5'd22:   v = 29'sd14;
      5'd23:   v = 29'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round to nearest (ties up) from 2^-20 degree to output units, then clamp to +-lim
  function automatic logic signed [ROLL_W-1:0] round_clamp(input logic signed [ZW-1:0] z,
                                                           input logic signed [ZW:0] lim);
    logic signed [ZW:0] s;
    s = ((ZW+1)'(z) + (ZW+1)'(1 << (RND_SH - 1))) >>> RND_SH;
    if (s > lim) begin
      s = lim;
    end else if (s < -lim) begin
      s = -lim;
    end
    return ROLL_W'(s);
  endfunction

endpackage

`default_nettype wire

[sv/ata_cordic.sv]
// Pipelined vectoring CORDIC: atan2(num, den) in 2^-20 degree, one vector per cycle while en is high.
`default_nettype none

module ata_cordic (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic signed [ata_pkg::CW-1:0]  num,
  input  wire logic signed [ata_pkg::CW-1:0]  den,
  output logic signed [ata_pkg::ZW-1:0]       angle
);

  // Stage 0 is the entry register, stages 1..STAGES the micro-rotations
  logic signed [ata_pkg::CW-1:0] x    [0:ata_pkg::STAGES];
  logic signed [ata_pkg::CW-1:0] y    [0:ata_pkg::STAGES];
  logic signed [ata_pkg::ZW-1:0] z    [0:ata_pkg::STAGES];
  logic                          hold [0:ata_pkg::STAGES];

  // Entry: axis special cases and quadrant pre-rotation for a negative denominator
  always_ff @(posedge clk) begin
    if (en) begin
      if (num == '0) begin
        x[0]    <= den;
        y[0]    <= num;
        z[0]    <= (den < 0) ? ata_pkg::HALF_TURN_Z : '0;
        hold[0] <= 1'b1;
      end else if (den == '0) begin
        x[0]    <= den;
        y[0]    <= num;
        z[0]    <= (num > 0) ? ata_pkg::QUARTER_TURN_Z : -ata_pkg::QUARTER_TURN_Z;
        hold[0] <= 1'b1;
      end else if (den < 0) begin
        hold[0] <= 1'b0;
        if (num > 0) begin
          x[0] <= num;
          y[0] <= -den;
          z[0] <= ata_pkg::QUARTER_TURN_Z;
        end else begin
          x[0] <= -num;
          y[0] <= den;
          z[0] <= -ata_pkg::QUARTER_TURN_Z;
        end
      end else begin
        x[0]    <= den;
        y[0]    <= num;
        z[0]    <= '0;
        hold[0] <= 1'b0;
      end
    end
  end

  // Micro-rotation stages, one register stage each
  for (genvar i = 0; i < ata_pkg::STAGES; i++) begin : g_stage
    logic signed [ata_pkg::CW-1:0] dx;
    logic signed [ata_pkg::CW-1:0] dy;
    logic signed [ata_pkg::ZW-1:0] da;

    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;
    assign da = ata_pkg::atan_tab(ata_pkg::TAB_IDX_W'(i));

    always_ff @(posedge clk) begin
      if (en) begin
        hold[i+1] <= hold[i];
        if (y[i] >= 0) begin
          x[i+1] <= x[i] + dx;
          y[i+1] <= y[i] - dy;
        end else begin
          x[i+1] <= x[i] - dx;
          y[i+1] <= y[i] + dy;
        end
        if (hold[i]) begin
          z[i+1] <= z[i];
        end else if (y[i] >= 0) begin
          z[i+1] <= z[i] + da;
        end else begin
          z[i+1] <= z[i] - da;
        end
      end
    end
  end

  assign angle = z[ata_pkg::STAGES];

endmodule

`default_nettype wire

[sv/accel_tilt_angles_top.sv]
// Accelerometer tilt angles: roll = atan2(y, z), pitch = atan2(-x, |(y, z)|), fully pipelined.
//
// Usage:
//   Sample channel: sample_valid / sample_stall with accel_x, accel_y, accel_z (signed counts).
//   A transfer happens on a rising edge with sample_valid high and sample_stall low.
//   Angle channel: angle_valid / angle_stall with roll_angle (16 bits) and pitch_angle
//   (15 bits), both signed in 1/128 degree.
// Throughput: one sample per clock while sample_stall is low.
// Latency: 45 register stages from the sample transfer to the angle register, set by the
//   24-step bit-serial root of y*y + z*z (one result bit per stage) followed by the
//   16-stage CORDIC that turns the root and x into pitch; roll runs in a parallel CORDIC.
// Stall: the whole pipeline moves together. When the receiver stalls, the angle register
//   holds its result and one more result drops into a skid register; only when the skid
//   register is full does sample_stall go high, so nothing is lost or repeated.
// Reset: rst (synchronous, active high) clears the valid bits, including those of the angle
//   register and the skid register. The data path registers are not reset; a sample can be
//   taken as soon as rst is low.
`default_nettype none

module accel_tilt_angles_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 sample_valid,
  output logic                                      sample_stall,
  input  wire logic signed [ata_pkg::SAMPLE_W-1:0]  accel_x,
  input  wire logic signed [ata_pkg::SAMPLE_W-1:0]  accel_y,
  input  wire logic signed [ata_pkg::SAMPLE_W-1:0]  accel_z,
  output logic                                      angle_valid,
  input  wire logic                                 angle_stall,
  output logic signed [ata_pkg::ROLL_W-1:0]         roll_angle,
  output logic signed [ata_pkg::PITCH_W-1:0]        pitch_angle
);

  localparam int CL = ata_pkg::STAGES + 1;

  // Pipeline advance: held only while the skid register carries a result
  logic adv;
  logic skid_valid;

  assign adv          = !skid_valid;
  assign sample_stall = skid_valid;

  // Input register
  logic                                v0;
  logic signed [ata_pkg::SAMPLE_W-1:0] ax0, ay0, az0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax0 <= accel_x;
      ay0 <= accel_y;
      az0 <= accel_z;
    end
  end

  // Squares of y and z
  logic                                v1;
  logic signed [ata_pkg::SAMPLE_W-1:0] ax1, ay1, az1;
  logic signed [ata_pkg::SUM_W-1:0]    yy1, zz1;
  logic signed [ata_pkg::SUM_W-1:0]    ay0_ext, az0_ext;

  assign ay0_ext = ata_pkg::SUM_W'(ay0);
  assign az0_ext = ata_pkg::SUM_W'(az0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax1 <= ax0;
      ay1 <= ay0;
      az1 <= az0;
      yy1 <= ay0_ext * ay0_ext;
      zz1 <= az0_ext * az0_ext;
    end
  end

  // Bit-serial square root: stage k settles root bit ROOT_W-1-k
  logic                                v_sq   [0:ata_pkg::ROOT_W];
  logic [ata_pkg::RAD_W-1:0]           rem_sq [0:ata_pkg::ROOT_W];
  logic [ata_pkg::ROOT_W-1:0]          root_sq[0:ata_pkg::ROOT_W];
  logic signed [ata_pkg::SAMPLE_W-1:0] ax_sq  [0:ata_pkg::ROOT_W];
  logic signed [ata_pkg::SAMPLE_W-1:0] ay_sq  [0:ata_pkg::ROOT_W];
  logic signed [ata_pkg::SAMPLE_W-1:0] az_sq  [0:ata_pkg::ROOT_W];
  logic [ata_pkg::SUM_W-1:0]           sum1;

  assign sum1 = ata_pkg::SUM_W'(unsigned'(yy1) + unsigned'(zz1));

  always_ff @(posedge clk) begin
    if (rst) begin
      v_sq[0] <= 1'b0;
    end else if (adv) begin
      v_sq[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_sq[0]  <= {sum1, {(2 * ata_pkg::GUARD_SH){1'b0}}};
      root_sq[0] <= '0;
      ax_sq[0]   <= ax1;
      ay_sq[0]   <= ay1;
      az_sq[0]   <= az1;
    end
  end

  for (genvar k = 0; k < ata_pkg::ROOT_W; k++) begin : g_sqrt
    localparam int B = ata_pkg::ROOT_W - 1 - k;
    logic [ata_pkg::TRIAL_W-1:0] trial;
    logic [ata_pkg::TRIAL_W-1:0] rem_ext;

    // (R + 2^B)^2 - R^2 = R*2^(B+1) + 2^(2B)
    assign trial   = (ata_pkg::TRIAL_W'(root_sq[k]) << (B + 1))
                   | (ata_pkg::TRIAL_W'(1) << (2 * B));
    assign rem_ext = ata_pkg::TRIAL_W'(rem_sq[k]);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_sq[k+1] <= 1'b0;
      end else if (adv) begin
        v_sq[k+1] <= v_sq[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ax_sq[k+1] <= ax_sq[k];
        ay_sq[k+1] <= ay_sq[k];
        az_sq[k+1] <= az_sq[k];
        if (rem_ext >= trial) begin
          rem_sq[k+1]  <= ata_pkg::RAD_W'(rem_ext - trial);
          root_sq[k+1] <= root_sq[k] | (ata_pkg::ROOT_W'(1) << B);
        end else begin
          rem_sq[k+1]  <= rem_sq[k];
          root_sq[k+1] <= root_sq[k];
        end
      end
    end
  end

  // CORDIC operands, guard bits applied
  logic signed [ata_pkg::CW-1:0] roll_num, roll_den, pitch_num, pitch_den;
  logic signed [ata_pkg::CW-1:0] ax_ext;

  assign ax_ext    = ata_pkg::CW'(ax_sq[ata_pkg::ROOT_W]);
  assign roll_num  = ata_pkg::CW'(ay_sq[ata_pkg::ROOT_W]) <<< ata_pkg::GUARD_SH;
  assign roll_den  = ata_pkg::CW'(az_sq[ata_pkg::ROOT_W]) <<< ata_pkg::GUARD_SH;
  assign pitch_num = (-ax_ext) <<< ata_pkg::GUARD_SH;
  assign pitch_den = signed'(ata_pkg::CW'(root_sq[ata_pkg::ROOT_W]));

  logic signed [ata_pkg::ZW-1:0] roll_z, pitch_z;

  ata_cordic u_roll (
    .clk   (clk),
    .en    (adv),
    .num   (roll_num),
    .den   (roll_den),
    .angle (roll_z)
  );

  ata_cordic u_pitch (
    .clk   (clk),
    .en    (adv),
    .num   (pitch_num),
    .den   (pitch_den),
    .angle (pitch_z)
  );

  // Valid bits alongside the CORDIC stages
  logic [CL-1:0] v_cr;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_cr <= '0;
    end else if (adv) begin
      v_cr <= {v_cr[CL-2:0], v_sq[ata_pkg::ROOT_W]};
    end
  end

  // Rounding and saturation of the finished angles
  logic signed [ata_pkg::ROLL_W-1:0]  roll_next;
  logic signed [ata_pkg::ROLL_W-1:0]  pitch_wide;
  logic signed [ata_pkg::PITCH_W-1:0] pitch_next;

  assign roll_next  = ata_pkg::round_clamp(roll_z, (ata_pkg::ZW+1)'(ata_pkg::ROLL_LIM));
  assign pitch_wide = ata_pkg::round_clamp(pitch_z, (ata_pkg::ZW+1)'(ata_pkg::PITCH_LIM));
  assign pitch_next = pitch_wide[ata_pkg::PITCH_W-1:0];

  // Output register with one-entry skid
  logic signed [ata_pkg::ROLL_W-1:0]  skid_roll;
  logic signed [ata_pkg::PITCH_W-1:0] skid_pitch;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (skid_valid) begin
      if (!angle_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (!angle_valid || !angle_stall) begin
      angle_valid <= v_cr[CL-1];
    end else if (v_cr[CL-1]) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!angle_stall) begin
        roll_angle  <= skid_roll;
        pitch_angle <= skid_pitch;
      end
    end else if (!angle_valid || !angle_stall) begin
      roll_angle  <= roll_next;
      pitch_angle <= pitch_next;
    end else begin
      skid_roll  <= roll_next;
      skid_pitch <= pitch_next;
    end
  end

`ifndef SYNTHESIS
  // Skid register only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> angle_valid)
    else $error("skid register full while angle register empty");

  a_skid_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(angle_valid && angle_stall && v_cr[CL-1]))
    else $error("skid register filled without a stalled transfer");

  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_valid && angle_stall |=> skid_valid)
    else $error("skid result dropped under stall");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    angle_valid |-> (roll_angle <= 16'sd23040 && roll_angle >= -16'sd23040))
    else $error("roll angle out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    angle_valid |-> (pitch_angle <= 15'sd11520 && pitch_angle >= -15'sd11520))
    else $error("pitch angle out of range");
`endif

endmodule

`default_nettype wire
